@@ rtl/point_light_linear_falloff_macros.svh @@
// Assertion macros shared by the point light RTL files.
// The using scope must provide a clock named clk and an active-low reset named arst_n.
`ifndef POINT_LIGHT_LINEAR_FALLOFF_MACROS_SVH
`define POINT_LIGHT_LINEAR_FALLOFF_MACROS_SVH
`ifndef SYNTHESIS
`define PLF_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PLF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PLF_ASSERT_IMPLY(label, ante, cons, msg)
`define PLF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/plf_pkg.sv @@
// Types, widths and codes shared by the point light falloff block.
// No dependencies; every RTL module in the project imports this package.
`timescale 1ns / 1ps
`default_nettype none
package plf_pkg;

	localparam int COORD_W   = 24;
	localparam int DIF_W     = 25;
	localparam int MAG_W     = 25;
	localparam int SQ_W      = 49;
	localparam int SUM_W     = 50;
	localparam int RAD_W     = 62;
	localparam int ROOT_W    = 31;
	localparam int SREM_W    = 33;
	localparam int K_W       = 5;
	localparam int DIST_W    = 25;
	localparam int DREM_W    = 31;
	localparam int FEED_W    = 16;
	localparam int STR_W     = 16;
	localparam int PROD_W    = 40;
	localparam int OUT_W     = 16;
	localparam int NRM_STEPS  = 5;
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS  = 16;
	localparam int LANES      = 6;

	localparam logic [OUT_W-1:0] UNIT_ONE = 16'd16384;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] dir_x;
		logic signed [OUT_W-1:0] dir_y;
		logic signed [OUT_W-1:0] dir_z;
		logic [OUT_W-1:0]        lit_red;
		logic [OUT_W-1:0]        lit_green;
		logic [OUT_W-1:0]        lit_blue;
		logic                    zero_length;
	} result_t;

	typedef enum logic [3:0] {
		REG_LIGHT_POS_X    = 4'd0,
		REG_LIGHT_POS_Y    = 4'd1,
		REG_LIGHT_POS_Z    = 4'd2,
		REG_FALLOFF_START  = 4'd3,
		REG_FALLOFF_END    = 4'd4,
		REG_STRENGTH_RED   = 4'd5,
		REG_STRENGTH_GREEN = 4'd6,
		REG_STRENGTH_BLUE  = 4'd7
	} cfg_reg_e;

	typedef enum logic [1:0] {
		ATT_ZERO,
		ATT_FULL,
		ATT_DIV
	} att_mode_e;

	// One step of the digit-by-digit square root.
	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sqrt_stage_t;

	// One step of the restoring divider.
	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic [FEED_W-1:0] feed;
		logic [FEED_W-1:0] quo;
		logic [DREM_W-1:0] dvs;
	} div_stage_t;

endpackage
`default_nettype wire

@@ rtl/plf_sqrt_cell.sv @@
// One cell of the square root row: retires one root bit per cycle while en is high.
// Depends on plf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plf_sqrt_cell (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire plf_pkg::sqrt_stage_t  stage_in,
	output plf_pkg::sqrt_stage_t       stage_out
);
	import plf_pkg::*;

	logic [SREM_W+1:0] acc;
	logic [SREM_W+1:0] trial;
	logic [SREM_W+1:0] diff;
	logic              ge;
	sqrt_stage_t       nxt;
	sqrt_stage_t       stage_q;

	always_comb begin
		acc   = {stage_in.rem, stage_in.rad[RAD_W-1 -: 2]};
		trial = {2'b00, stage_in.root, 2'b01};
		diff  = acc - trial;
		ge    = (acc >= trial);
		nxt.rad  = {stage_in.rad[RAD_W-3:0], 2'b00};
		nxt.rem  = ge ? diff[SREM_W-1:0] : acc[SREM_W-1:0];
		nxt.root = {stage_in.root[ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= nxt;
		end
	end

	assign stage_out = stage_q;

endmodule
`default_nettype wire

@@ rtl/plf_div_cell.sv @@
// One cell of a divider row: retires one quotient bit per cycle while en is high.
// Depends on plf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plf_div_cell (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire plf_pkg::div_stage_t  stage_in,
	output plf_pkg::div_stage_t       stage_out
);
	import plf_pkg::*;

	logic [DREM_W:0] acc;
	logic [DREM_W:0] diff;
	logic            ge;
	div_stage_t      nxt;
	div_stage_t      stage_q;

	always_comb begin
		acc  = {stage_in.rem, stage_in.feed[FEED_W-1]};
		diff = acc - {1'b0, stage_in.dvs};
		ge   = (acc >= {1'b0, stage_in.dvs});
		nxt.rem  = ge ? diff[DREM_W-1:0] : acc[DREM_W-1:0];
		nxt.feed = {stage_in.feed[FEED_W-2:0], 1'b0};
		nxt.quo  = {stage_in.quo[FEED_W-2:0], ge};
		nxt.dvs  = stage_in.dvs;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q <= nxt;
		end
	end

	assign stage_out = stage_q;

endmodule
`default_nettype wire

@@ rtl/point_light_linear_falloff.sv @@
// Point light with linear distance falloff: top level.
// Depends on plf_pkg, plf_sqrt_cell, plf_div_cell and the assertion macro header.
//
// Usage: a surface point arrives on the point channel (point_valid, point_stall,
// point) and one result leaves on the result channel (result_valid, result_stall,
// result) for every point, in order. A transaction completes on a rising edge
// where valid is high and stall is low. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) writes the light position, falloff distances
// and color strengths; cfg_ready is always high and an unknown index is dropped.
// Throughput is one point per clock while point_stall is low. The pipeline
// depth from the point transaction to result_valid is mostly set by the row of 31
// square root cells and the rows of 16 divider cells. While the result
// register holds an untaken result the pipeline keeps moving until a finished
// result reaches its end; only then does point_stall rise. Reset clears all
// configuration registers to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "point_light_linear_falloff_macros.svh"
module point_light_linear_falloff (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             point_valid,
	output logic                  point_stall,
	input  wire plf_pkg::point_t  point,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output plf_pkg::result_t      result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [3:0]       cfg_index,
	input  wire logic [23:0]      cfg_data
);
	import plf_pkg::*;

	// Configuration registers.
	logic signed [COORD_W-1:0] light_q [3];
	logic [COORD_W-1:0]        falloff_start_q;
	logic [COORD_W-1:0]        falloff_end_q;
	logic [STR_W-1:0]          strength_q [3];

	// Global advance: the whole pipeline moves unless a finished result sits
	// at its end while the result register is full and stalled.
	logic adv;

	logic signed [COORD_W-1:0] pnt [3];

	// Front end: difference, squares, sum.
	logic signed [DIF_W-1:0] d_s1 [3];
	logic                    vld_s1;
	logic signed [SUM_W-1:0] sq_full [3];
	logic [MAG_W-1:0]        mag_c [3];
	logic [SQ_W-1:0]         sq_s2 [3];
	logic [2:0][MAG_W-1:0]   mag_s2;
	logic [2:0]              sign_s2;
	logic                    zero_s2;
	logic                    vld_s2;
	logic [SUM_W-1:0]        sum_s3;
	logic [2:0][MAG_W-1:0]   mag_s3;
	logic [2:0]              sign_s3;
	logic                    zero_s3;
	logic                    vld_s3;

	// Normalizing shifter banks, one entry per shift stage.
	logic [RAD_W-1:0]         nrm_rad_q  [NRM_STEPS];
	logic [K_W-1:0]           nrm_k_q    [NRM_STEPS];
	logic [2:0][ROOT_W-1:0]   nrm_m_q    [NRM_STEPS];
	logic [2:0]               nrm_sign_q [NRM_STEPS];
	logic                     nrm_zero_q [NRM_STEPS];
	logic                     nrm_vld_q  [NRM_STEPS];

	// Square root row with its side band.
	sqrt_stage_t              sqrt_link   [SQRT_STEPS+1];
	logic [K_W-1:0]           sqrt_k_q    [SQRT_STEPS];
	logic [2:0][ROOT_W-1:0]   sqrt_m_q    [SQRT_STEPS];
	logic [2:0]               sqrt_sign_q [SQRT_STEPS];
	logic                     sqrt_zero_q [SQRT_STEPS];
	logic                     sqrt_vld_q  [SQRT_STEPS];

	// Distance and attenuation setup.
	logic [ROOT_W-1:0]      root_shift;
	logic [ROOT_W-1:0]      len_s40;
	logic [DIST_W-1:0]      dist_s40;
	logic [2:0][ROOT_W-1:0] m_s40;
	logic [2:0]             sign_s40;
	logic                   zero_s40;
	logic                   vld_s40;
	att_mode_e              mode_c;
	att_mode_e              mode_s41;
	logic [COORD_W-1:0]     diff_s41;
	logic [COORD_W-1:0]     span_s41;
	logic [ROOT_W-1:0]      len_s41;
	logic [2:0][ROOT_W-1:0] m_s41;
	logic [2:0]             sign_s41;
	logic                   zero_s41;
	logic                   vld_s41;
	logic [PROD_W-1:0]      prod_c [3];
	div_stage_t             lane_s42 [LANES];
	att_mode_e              mode_s42;
	logic [2:0]             sign_s42;
	logic                   zero_s42;
	logic                   vld_s42;

	// Divider rows: lanes 0 to 2 are the unit vector, 3 to 5 the colors.
	div_stage_t  div_link   [LANES][DIV_STEPS+1];
	att_mode_e   div_mode_q [DIV_STEPS];
	logic [2:0]  div_sign_q [DIV_STEPS];
	logic        div_zero_q [DIV_STEPS];
	logic        div_vld_q  [DIV_STEPS];

	// Output register.
	logic [OUT_W:0]   rnd_c [3];
	logic [OUT_W-1:0] qv_c [3];
	logic [OUT_W-1:0] dir_c [3];
	logic [OUT_W-1:0] lit_c [3];
	result_t          res_nxt;
	result_t          result_q;
	logic             result_valid_q;

	//------------------------------------------------------------------
	// Configuration port. Writes are only expected while the block is idle.
	//------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				light_q[a]    <= '0;
				strength_q[a] <= '0;
			end
			falloff_start_q <= '0;
			falloff_end_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LIGHT_POS_X:    light_q[0]      <= cfg_data;
				REG_LIGHT_POS_Y:    light_q[1]      <= cfg_data;
				REG_LIGHT_POS_Z:    light_q[2]      <= cfg_data;
				REG_FALLOFF_START:  falloff_start_q <= cfg_data;
				REG_FALLOFF_END:    falloff_end_q   <= cfg_data;
				REG_STRENGTH_RED:   strength_q[0]   <= cfg_data[STR_W-1:0];
				REG_STRENGTH_GREEN: strength_q[1]   <= cfg_data[STR_W-1:0];
				REG_STRENGTH_BLUE:  strength_q[2]   <= cfg_data[STR_W-1:0];
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Flow control. A stall freezes every stage at once; a result only
	// blocks the pipeline when one is actually waiting behind it.
	//------------------------------------------------------------------
	assign adv         = !(result_valid_q && result_stall && div_vld_q[DIV_STEPS-1]);
	assign point_stall = !adv;

	assign pnt[0] = point.point_x;
	assign pnt[1] = point.point_y;
	assign pnt[2] = point.point_z;

	//------------------------------------------------------------------
	// Stage 1: vector from the point to the light, exact in 25 bits.
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				d_s1[a] <= {light_q[a][COORD_W-1], light_q[a]} - {pnt[a][COORD_W-1], pnt[a]};
			end
		end
	end

	//------------------------------------------------------------------
	// Stage 2: squares and magnitudes. Squaring the signed value directly
	// keeps the absolute value off the multiplier path.
	//------------------------------------------------------------------
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sq_full[a] = d_s1[a] * d_s1[a];
			mag_c[a]   = d_s1[a][DIF_W-1] ? (MAG_W'(0) - d_s1[a]) : d_s1[a];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				sq_s2[a]   <= sq_full[a][SQ_W-1:0];
				mag_s2[a]  <= mag_c[a];
				sign_s2[a] <= d_s1[a][DIF_W-1];
			end
			zero_s2 <= (d_s1[0] == '0) && (d_s1[1] == '0) && (d_s1[2] == '0);
		end
	end

	// Stage 3: squared length.
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3  <= {1'b0, sq_s2[0]} + {1'b0, sq_s2[1]} + {1'b0, sq_s2[2]};
			mag_s3  <= mag_s2;
			sign_s3 <= sign_s2;
			zero_s3 <= zero_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= point_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	//------------------------------------------------------------------
	// Stages 4 to 8: normalize the squared length by an even shift so that
	// it lands in [2^60, 2^62). Each stage tries one power of two of the
	// shift, largest first, and shifts the magnitudes by half as much.
	//------------------------------------------------------------------
	for (genvar j = 0; j < NRM_STEPS; j++) begin : g_nrm
		localparam int PAIRS = 1 << (NRM_STEPS - 1 - j);
		logic [RAD_W-1:0]       rad_in;
		logic [K_W-1:0]         k_in;
		logic [2:0][ROOT_W-1:0] m_in;
		logic [2:0]             sign_in;
		logic                   zero_in;
		logic                   vld_in;
		logic                   fits;

		if (j == 0) begin : g_first
			assign rad_in  = {{(RAD_W-SUM_W){1'b0}}, sum_s3};
			assign k_in    = '0;
			assign sign_in = sign_s3;
			assign zero_in = zero_s3;
			assign vld_in  = vld_s3;
			for (genvar a = 0; a < 3; a++) begin : g_m
				assign m_in[a] = {{(ROOT_W-MAG_W){1'b0}}, mag_s3[a]};
			end
		end else begin : g_next
			assign rad_in  = nrm_rad_q[j-1];
			assign k_in    = nrm_k_q[j-1];
			assign m_in    = nrm_m_q[j-1];
			assign sign_in = nrm_sign_q[j-1];
			assign zero_in = nrm_zero_q[j-1];
			assign vld_in  = nrm_vld_q[j-1];
		end

		assign fits = (rad_in[RAD_W-1 -: 2*PAIRS] == '0);

		always_ff @(posedge clk) begin
			if (adv) begin
				nrm_rad_q[j] <= fits ? (rad_in << (2*PAIRS)) : rad_in;
				nrm_k_q[j]   <= fits ? (k_in + K_W'(PAIRS)) : k_in;
				for (int a = 0; a < 3; a++) begin
					nrm_m_q[j][a] <= fits ? (m_in[a] << PAIRS) : m_in[a];
				end
				nrm_sign_q[j] <= sign_in;
				nrm_zero_q[j] <= zero_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nrm_vld_q[j] <= 1'b0;
			end else if (adv) begin
				nrm_vld_q[j] <= vld_in;
			end
		end
	end

	//------------------------------------------------------------------
	// Stages 9 to 39: square root of the normalized value, one root bit per
	// cell. The shift count and shifted magnitudes ride alongside.
	//------------------------------------------------------------------
	assign sqrt_link[0].rad  = nrm_rad_q[NRM_STEPS-1];
	assign sqrt_link[0].rem  = '0;
	assign sqrt_link[0].root = '0;

	for (genvar c = 0; c < SQRT_STEPS; c++) begin : g_sqrt
		plf_sqrt_cell u_cell (
			.clk       (clk),
			.en        (adv),
			.stage_in  (sqrt_link[c]),
			.stage_out (sqrt_link[c+1])
		);

		if (c == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					sqrt_k_q[c]    <= nrm_k_q[NRM_STEPS-1];
					sqrt_m_q[c]    <= nrm_m_q[NRM_STEPS-1];
					sqrt_sign_q[c] <= nrm_sign_q[NRM_STEPS-1];
					sqrt_zero_q[c] <= nrm_zero_q[NRM_STEPS-1];
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sqrt_vld_q[c] <= 1'b0;
				end else if (adv) begin
					sqrt_vld_q[c] <= nrm_vld_q[NRM_STEPS-1];
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					sqrt_k_q[c]    <= sqrt_k_q[c-1];
					sqrt_m_q[c]    <= sqrt_m_q[c-1];
					sqrt_sign_q[c] <= sqrt_sign_q[c-1];
					sqrt_zero_q[c] <= sqrt_zero_q[c-1];
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sqrt_vld_q[c] <= 1'b0;
				end else if (adv) begin
					sqrt_vld_q[c] <= sqrt_vld_q[c-1];
				end
			end
		end
	end

	//------------------------------------------------------------------
	// Stage 40: undo the normalization to get floor(sqrt) of the squared
	// length, which is the distance in Q.8.
	//------------------------------------------------------------------
	assign root_shift = sqrt_link[SQRT_STEPS].root >> sqrt_k_q[SQRT_STEPS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			len_s40  <= sqrt_link[SQRT_STEPS].root;
			dist_s40 <= root_shift[DIST_W-1:0];
			m_s40    <= sqrt_m_q[SQRT_STEPS-1];
			sign_s40 <= sqrt_sign_q[SQRT_STEPS-1];
			zero_s40 <= sqrt_zero_q[SQRT_STEPS-1];
		end
	end

	//------------------------------------------------------------------
	// Stage 41: pick the falloff region. The end test comes first, so a
	// span that is empty or inverted never reaches the divider.
	//------------------------------------------------------------------
	always_comb begin
		if (dist_s40 >= {1'b0, falloff_end_q}) begin
			mode_c = ATT_ZERO;
		end else if (dist_s40 <= {1'b0, falloff_start_q}) begin
			mode_c = ATT_FULL;
		end else begin
			mode_c = ATT_DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s41 <= mode_c;
			diff_s41 <= falloff_end_q - dist_s40[COORD_W-1:0];
			span_s41 <= falloff_end_q - falloff_start_q;
			len_s41  <= len_s40;
			m_s41    <= m_s40;
			sign_s41 <= sign_s40;
			zero_s41 <= zero_s40;
		end
	end

	//------------------------------------------------------------------
	// Stage 42: load the divider lanes. The unit lanes divide m * 2^15 by
	// the root, where m is the magnitude shifted like the squared length,
	// so m never exceeds the root and the quotient fits in 16 bits. The
	// color lanes divide strength * (end - distance) by the span.
	//------------------------------------------------------------------
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			prod_c[a] = strength_q[a] * diff_s41;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				lane_s42[a].rem  <= {1'b0, m_s41[a][ROOT_W-1:1]};
				lane_s42[a].feed <= {m_s41[a][0], {(FEED_W-1){1'b0}}};
				lane_s42[a].quo  <= '0;
				lane_s42[a].dvs  <= len_s41;
				lane_s42[a+3].rem  <= {{(DREM_W-COORD_W){1'b0}}, prod_c[a][PROD_W-1:FEED_W]};
				lane_s42[a+3].feed <= prod_c[a][FEED_W-1:0];
				lane_s42[a+3].quo  <= '0;
				lane_s42[a+3].dvs  <= {{(DREM_W-COORD_W){1'b0}}, span_s41};
			end
			mode_s42 <= mode_s41;
			sign_s42 <= sign_s41;
			zero_s42 <= zero_s41;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s40 <= 1'b0;
			vld_s41 <= 1'b0;
			vld_s42 <= 1'b0;
		end else if (adv) begin
			vld_s40 <= sqrt_vld_q[SQRT_STEPS-1];
			vld_s41 <= vld_s40;
			vld_s42 <= vld_s41;
		end
	end

	//------------------------------------------------------------------
	// Stages 43 to 58: six divider rows, one quotient bit per cell.
	//------------------------------------------------------------------
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		assign div_link[l][0] = lane_s42[l];
		for (genvar c = 0; c < DIV_STEPS; c++) begin : g_cell
			plf_div_cell u_cell (
				.clk       (clk),
				.en        (adv),
				.stage_in  (div_link[l][c]),
				.stage_out (div_link[l][c+1])
			);
		end
	end

	for (genvar c = 0; c < DIV_STEPS; c++) begin : g_div_side
		if (c == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					div_mode_q[c] <= mode_s42;
					div_sign_q[c] <= sign_s42;
					div_zero_q[c] <= zero_s42;
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					div_vld_q[c] <= 1'b0;
				end else if (adv) begin
					div_vld_q[c] <= vld_s42;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					div_mode_q[c] <= div_mode_q[c-1];
					div_sign_q[c] <= div_sign_q[c-1];
					div_zero_q[c] <= div_zero_q[c-1];
				end
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					div_vld_q[c] <= 1'b0;
				end else if (adv) begin
					div_vld_q[c] <= div_vld_q[c-1];
				end
			end
		end
	end

	//------------------------------------------------------------------
	// Output. The unit quotient carries one extra fraction bit, so adding
	// one and dropping that bit rounds to nearest with ties away from zero
	// on the magnitude; the sign is applied afterwards.
	//------------------------------------------------------------------
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			rnd_c[a] = {1'b0, div_link[a][DIV_STEPS].quo} + {{OUT_W{1'b0}}, 1'b1};
			qv_c[a]  = (rnd_c[a][OUT_W:1] > UNIT_ONE) ? UNIT_ONE : rnd_c[a][OUT_W:1];
			if (div_zero_q[DIV_STEPS-1]) begin
				dir_c[a] = '0;
			end else if (div_sign_q[DIV_STEPS-1][a]) begin
				dir_c[a] = OUT_W'(0) - qv_c[a];
			end else begin
				dir_c[a] = qv_c[a];
			end
			case (div_mode_q[DIV_STEPS-1])
				ATT_ZERO: lit_c[a] = '0;
				ATT_FULL: lit_c[a] = strength_q[a];
				default:  lit_c[a] = div_link[a+3][DIV_STEPS].quo;
			endcase
		end
		res_nxt.dir_x       = dir_c[0];
		res_nxt.dir_y       = dir_c[1];
		res_nxt.dir_z       = dir_c[2];
		res_nxt.lit_red     = lit_c[0];
		res_nxt.lit_green   = lit_c[1];
		res_nxt.lit_blue    = lit_c[2];
		res_nxt.zero_length = div_zero_q[DIV_STEPS-1];
	end

	always_ff @(posedge clk) begin
		if (adv && div_vld_q[DIV_STEPS-1]) begin
			result_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv && div_vld_q[DIV_STEPS-1]) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	// An empty result register never holds back the point channel.
	`PLF_ASSERT_IMPLY(a_empty_no_stall, !result_valid, !point_stall, "point stalled with empty output")
	// A finished result that moves forward always lands in the result register.
	`PLF_ASSERT_NEXT(a_last_loads, adv && div_vld_q[DIV_STEPS-1], result_valid, "finished result lost")
	// A zero-length vector yields a zero direction.
	`PLF_ASSERT_IMPLY(a_zero_dir, result_valid && result.zero_length, (result.dir_x == '0) && (result.dir_y == '0) && (result.dir_z == '0), "nonzero direction for zero vector")
	// Direction components stay within plus and minus one in Q1.14.
	`PLF_ASSERT_IMPLY(a_dir_range, result_valid, (result.dir_x <= 16'sd16384) && (result.dir_x >= -16'sd16384) && (result.dir_y <= 16'sd16384) && (result.dir_y >= -16'sd16384) && (result.dir_z <= 16'sd16384) && (result.dir_z >= -16'sd16384), "direction out of range")

endmodule
`default_nettype wire
